FILE: hw/rtl/suf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suf_pkg: shared types and constants
// Register map, fixed field widths, smoothstep constants and the command and
// status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package suf_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_GAIN      = 2'd1;

  // Register widths and reset values
  localparam int RLEN_W = 12;
  localparam int GAIN_W = 24;

  localparam logic [RLEN_W-1:0] RLEN_RESET = 12'd480;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd16696926;

  localparam logic [RLEN_W-1:0] MIN_FADE_FRAMES = 12'd8;

  // Blend weight is Q1.16: 17 bits cover 0 .. 1.0 inclusive.
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_W    = 17;
  localparam int POLY_W      = 18;

  // 3.0 in Q2.16, the constant term of 3 - 2x.
  localparam logic [POLY_W-1:0] POLY_THREE = 18'd196608;

  // One quotient bit per step: the integer bit plus the 16 fraction bits.
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECAY_L,
    OP_DECAY_R,
    OP_DECAY_END,
    OP_DIV,
    OP_SQUARE,
    OP_POLY,
    OP_BLEND_L,
    OP_BLEND_R,
    OP_BLEND_END,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    PATH_CLEAR,
    PATH_STARVE,
    PATH_PASS,
    PATH_FADE
  } path_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    path_e path;
    logic  out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/suf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suf_ctrl: frame sequencer
// Accepts one item at a time, steps the datapath through decay or through
// divide, weight and blend, and hands the result to the output register.
// ----------------------------------------------------------------------------
module suf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire suf_pkg::status_t status_i,
  output suf_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY_L,
    ST_DECAY_R,
    ST_DECAY_END,
    ST_DIV,
    ST_SQUARE,
    ST_POLY,
    ST_BLEND_L,
    ST_BLEND_R,
    ST_BLEND_END,
    ST_FINISH
  } state_e;

  state_e                        state_q;
  logic                          ready_q;
  logic [suf_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    case (state_q)
      ST_IDLE:      cmd_o.op = accept ? suf_pkg::OP_LOAD : suf_pkg::OP_NONE;
      ST_DECAY_L:   cmd_o.op = suf_pkg::OP_DECAY_L;
      ST_DECAY_R:   cmd_o.op = suf_pkg::OP_DECAY_R;
      ST_DECAY_END: cmd_o.op = suf_pkg::OP_DECAY_END;
      ST_DIV:       cmd_o.op = suf_pkg::OP_DIV;
      ST_SQUARE:    cmd_o.op = suf_pkg::OP_SQUARE;
      ST_POLY:      cmd_o.op = suf_pkg::OP_POLY;
      ST_BLEND_L:   cmd_o.op = suf_pkg::OP_BLEND_L;
      ST_BLEND_R:   cmd_o.op = suf_pkg::OP_BLEND_R;
      ST_BLEND_END: cmd_o.op = suf_pkg::OP_BLEND_END;
      ST_FINISH:    cmd_o.op = status_i.out_free ? suf_pkg::OP_EMIT : suf_pkg::OP_NONE;
      default:      cmd_o.op = suf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (status_i.path)
              suf_pkg::PATH_CLEAR: begin
                state_q <= ST_IDLE;
              end
              suf_pkg::PATH_STARVE: begin
                state_q <= ST_DECAY_L;
                ready_q <= 1'b0;
              end
              suf_pkg::PATH_PASS: begin
                state_q <= ST_FINISH;
                ready_q <= 1'b0;
              end
              suf_pkg::PATH_FADE: begin
                state_q <= ST_DIV;
                ready_q <= 1'b0;
                cnt_q   <= suf_pkg::DIV_CNT_W'(suf_pkg::DIV_STEPS - 1);
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DECAY_L:   state_q <= ST_DECAY_R;
        ST_DECAY_R:   state_q <= ST_DECAY_END;
        ST_DECAY_END: state_q <= ST_FINISH;
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_SQUARE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SQUARE:    state_q <= ST_POLY;
        ST_POLY:      state_q <= ST_BLEND_L;
        ST_BLEND_L:   state_q <= ST_BLEND_R;
        ST_BLEND_R:   state_q <= ST_BLEND_END;
        ST_BLEND_END: state_q <= ST_FINISH;
        ST_FINISH: begin
          // Wait here until the output register can take the result.
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/suf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suf_datapath: concealment state, shared multiplier and divider
// Holds the configuration registers, the starvation and fade state, a radix-2
// divider for the fade position and one shared registered multiplier for the
// decay, smoothstep and blend products, plus the output register.
// ----------------------------------------------------------------------------
module suf_datapath #(
  parameter int SAMPLE_BITS     = 24,
  parameter int MAX_FADE_FRAMES = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire suf_pkg::cmd_t                    cmd_i,
  output suf_pkg::status_t                      status_o,
  input  wire logic                             cfg_valid_i,
  input  wire logic [suf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [suf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             mode_i,
  input  wire logic                             available_i,
  input  wire logic                             mark_break_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_right_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]         out_left_o,
  output logic signed [SAMPLE_BITS-1:0]         out_right_o,
  output logic                                  episode_start_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int LW = $clog2(MAX_FADE_FRAMES) + 1;
  localparam int MA = (SAMPLE_BITS + 1 > suf_pkg::POLY_W) ? SAMPLE_BITS + 1 : suf_pkg::POLY_W;
  localparam int PW = MA + suf_pkg::GAIN_W;

  // Configuration
  logic [suf_pkg::RLEN_W-1:0] rlen_q;
  logic [suf_pkg::GAIN_W-1:0] gain_q;

  // Concealment state
  logic          starving_q;
  logic          brk_q;
  logic [LW-1:0] fade_rem_q;
  logic [SB-1:0] held_l_q, held_r_q;
  logic [SB-1:0] start_l_q, start_r_q;

  // Working registers
  logic [SB-1:0]                 in_l_q, in_r_q;
  logic [SB-1:0]                 res_l_q, res_r_q;
  logic                          res_ep_q;
  logic [LW-1:0]                 len_q, rem_q;
  logic [suf_pkg::WEIGHT_W-1:0]  x_q, w_q;
  logic [PW-1:0]                 prod_q;

  // Output register
  logic          out_valid_q;
  logic [SB-1:0] out_l_q, out_r_q;
  logic          out_ep_q;

  // Frame decode
  logic [LW-1:0] eff_len, fr_new, progress;
  logic          brk_now, fade_begin;

  always_comb begin
    if (rlen_q < suf_pkg::MIN_FADE_FRAMES) begin
      eff_len = LW'(suf_pkg::MIN_FADE_FRAMES);
    end else if (32'(rlen_q) > 32'(MAX_FADE_FRAMES)) begin
      eff_len = LW'(MAX_FADE_FRAMES);
    end else begin
      eff_len = LW'(rlen_q);
    end
  end

  assign brk_now    = brk_q | mark_break_i;
  assign fade_begin = starving_q | brk_now;
  assign fr_new     = fade_begin ? eff_len : fade_rem_q;
  // A length shortened during a fade restarts progress at the first frame.
  assign progress   = (fr_new > eff_len) ? LW'(1) : eff_len - fr_new + LW'(1);

  always_comb begin
    if (mode_i) begin
      status_o.path = suf_pkg::PATH_CLEAR;
    end else if (!available_i) begin
      status_o.path = suf_pkg::PATH_STARVE;
    end else if (fr_new != '0) begin
      status_o.path = suf_pkg::PATH_FADE;
    end else begin
      status_o.path = suf_pkg::PATH_PASS;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;

  // Magnitudes for the sign-magnitude products (truncation toward zero).
  logic [SB-1:0] held_l_mag, held_r_mag;
  logic [SB:0]   diff_l, diff_r, diff_l_mag, diff_r_mag;

  assign held_l_mag = held_l_q[SB-1] ? SB'(-held_l_q) : held_l_q;
  assign held_r_mag = held_r_q[SB-1] ? SB'(-held_r_q) : held_r_q;
  assign diff_l     = {in_l_q[SB-1], in_l_q} - {start_l_q[SB-1], start_l_q};
  assign diff_r     = {in_r_q[SB-1], in_r_q} - {start_r_q[SB-1], start_r_q};
  assign diff_l_mag = diff_l[SB] ? (SB+1)'(-diff_l) : diff_l;
  assign diff_r_mag = diff_r[SB] ? (SB+1)'(-diff_r) : diff_r;

  // Shared multiplier operand select
  logic [MA-1:0]                 mul_a;
  logic [suf_pkg::GAIN_W-1:0]    mul_b;
  logic [suf_pkg::POLY_W-1:0]    poly;
  logic [suf_pkg::WEIGHT_W-1:0]  prod_hi;

  assign poly    = suf_pkg::POLY_THREE - {x_q, 1'b0};
  assign prod_hi = prod_q[suf_pkg::WEIGHT_FRAC +: suf_pkg::WEIGHT_W];

  always_comb begin
    case (cmd_i.op)
      suf_pkg::OP_DECAY_L: begin
        mul_a = MA'(held_l_mag);
        mul_b = gain_q;
      end
      suf_pkg::OP_DECAY_R: begin
        mul_a = MA'(held_r_mag);
        mul_b = gain_q;
      end
      suf_pkg::OP_SQUARE: begin
        mul_a = MA'(x_q);
        mul_b = suf_pkg::GAIN_W'(x_q);
      end
      suf_pkg::OP_POLY: begin
        mul_a = MA'(poly);
        mul_b = suf_pkg::GAIN_W'(prod_hi);
      end
      suf_pkg::OP_BLEND_L: begin
        mul_a = MA'(diff_l_mag);
        mul_b = suf_pkg::GAIN_W'(prod_hi);
      end
      suf_pkg::OP_BLEND_R: begin
        mul_a = MA'(diff_r_mag);
        mul_b = suf_pkg::GAIN_W'(w_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product consumers
  logic [SB-1:0] dec_mag, dec_l, dec_r;
  logic [SB:0]   bl_mag;
  logic [SB-1:0] bl_l, bl_r;

  assign dec_mag = prod_q[suf_pkg::GAIN_W +: SB];
  assign dec_l   = held_l_q[SB-1] ? SB'(-dec_mag) : dec_mag;
  assign dec_r   = held_r_q[SB-1] ? SB'(-dec_mag) : dec_mag;
  assign bl_mag  = prod_q[suf_pkg::WEIGHT_FRAC +: SB+1];
  assign bl_l    = SB'({start_l_q[SB-1], start_l_q} + (diff_l[SB] ? (SB+1)'(-bl_mag) : bl_mag));
  assign bl_r    = SB'({start_r_q[SB-1], start_r_q} + (diff_r[SB] ? (SB+1)'(-bl_mag) : bl_mag));

  // Restoring divide step for floor(progress * 2^16 / length)
  logic          div_ge;
  logic [LW-1:0] div_rem;

  assign div_ge  = rem_q >= len_q;
  assign div_rem = div_ge ? rem_q - len_q : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlen_q      <= suf_pkg::RLEN_RESET;
      gain_q      <= suf_pkg::GAIN_RESET;
      starving_q  <= 1'b0;
      brk_q       <= 1'b0;
      fade_rem_q  <= '0;
      held_l_q    <= '0;
      held_r_q    <= '0;
      start_l_q   <= '0;
      start_r_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          suf_pkg::CFG_RECOVERY_LENGTH: rlen_q <= cfg_data_i[suf_pkg::RLEN_W-1:0];
          suf_pkg::CFG_DECAY_GAIN:      gain_q <= cfg_data_i[suf_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.op == suf_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (cmd_i.op)
        suf_pkg::OP_LOAD: begin
          if (mode_i) begin
            starving_q <= 1'b0;
            brk_q      <= 1'b0;
            fade_rem_q <= '0;
            held_l_q   <= '0;
            held_r_q   <= '0;
            start_l_q  <= '0;
            start_r_q  <= '0;
          end else if (!available_i) begin
            // A break mark seen while starving waits for the next live frame.
            starving_q <= 1'b1;
            brk_q      <= brk_now;
            fade_rem_q <= '0;
          end else begin
            starving_q <= 1'b0;
            brk_q      <= 1'b0;
            fade_rem_q <= (fr_new != '0) ? fr_new - 1'b1 : '0;
            if (fade_begin) begin
              start_l_q <= held_l_q;
              start_r_q <= held_r_q;
            end
          end
        end
        suf_pkg::OP_DECAY_R:   held_l_q <= dec_l;
        suf_pkg::OP_DECAY_END: held_r_q <= dec_r;
        suf_pkg::OP_EMIT: begin
          held_l_q <= res_l_q;
          held_r_q <= res_r_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
    case (cmd_i.op)
      suf_pkg::OP_LOAD: begin
        in_l_q   <= in_left_i;
        in_r_q   <= in_right_i;
        res_l_q  <= in_left_i;
        res_r_q  <= in_right_i;
        res_ep_q <= ~available_i & ~starving_q;
        rem_q    <= progress;
        len_q    <= eff_len;
      end
      suf_pkg::OP_DECAY_R:   res_l_q <= dec_l;
      suf_pkg::OP_DECAY_END: res_r_q <= dec_r;
      suf_pkg::OP_DIV: begin
        rem_q <= {div_rem[LW-2:0], 1'b0};
        x_q   <= {x_q[suf_pkg::WEIGHT_W-2:0], div_ge};
      end
      suf_pkg::OP_BLEND_L:   w_q     <= prod_hi;
      suf_pkg::OP_BLEND_R:   res_l_q <= bl_l;
      suf_pkg::OP_BLEND_END: res_r_q <= bl_r;
      suf_pkg::OP_EMIT: begin
        out_l_q  <= res_l_q;
        out_r_q  <= res_r_q;
        out_ep_q <= res_ep_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_left_o      = out_l_q;
  assign out_right_o     = out_r_q;
  assign episode_start_o = out_ep_q;

endmodule
`default_nettype wire

FILE: hw/rtl/stereo_underrun_fade_recovery_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_underrun_fade_recovery_core: stereo underrun concealment
// Decays the last output while input is starved and crossfades back to live
// input with a smoothstep weight after starvation or a discontinuity mark.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid/in_ready      mode, available, mark_break,
//                                              in_left, in_right
//   out      output     out_valid/out_ready    out_left, out_right,
//                                              episode_start
//   cfg      input      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A clear command resets concealment state, a passed-through frame goes to
// output directly, a starved frame is decayed, and a fading frame runs the
// 17-step radix-2 divider, then four passes of the one shared multiplier.
// One frame is in work at a time; the output register holds a finished
// result while the next frame is accepted. Reset clears all concealment
// state and loads the default registers. cfg_ready is always high.
// ----------------------------------------------------------------------------
module stereo_underrun_fade_recovery_core #(
  parameter int SAMPLE_BITS     = 24,
  parameter int MAX_FADE_FRAMES = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic                             available_i,
  input  wire logic                             mark_break_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_right_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         out_left_o,
  output logic signed [SAMPLE_BITS-1:0]         out_right_o,
  output logic                                  episode_start_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [suf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [suf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  suf_pkg::cmd_t    cmd;
  suf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  suf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  suf_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .MAX_FADE_FRAMES (MAX_FADE_FRAMES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .available_i     (available_i),
    .mark_break_i    (mark_break_i),
    .in_left_i       (in_left_i),
    .in_right_i      (in_right_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_left_o      (out_left_o),
    .out_right_o     (out_right_o),
    .episode_start_o (episode_start_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/suf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suf_checker: port-level assertions
// Checks item occupancy of the input side and the output hold rule, and is
// bound to the top level.
// ----------------------------------------------------------------------------
module suf_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   mode_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] out_left_o,
  input wire logic [SAMPLE_BITS-1:0] out_right_o,
  input wire logic                   episode_start_o
);

  // A frame beat occupies the block, so the next cycle cannot take another.
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !mode_i) |=> !in_ready_o)
    else $error("input ready after a frame beat");

  // A clear command produces no work and leaves the input side open.
  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i) |=> in_ready_o)
    else $error("input not ready after a clear beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_left_o) && $stable(out_right_o) &&
       $stable(episode_start_o)))
    else $error("stalled output beat changed");

endmodule

bind stereo_underrun_fade_recovery_core suf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_suf_checker (.*);
`default_nettype wire

FILE: sim/suf_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suf_frame_checker: concealment predictor and result scoreboard
// Watches the frame, result and register channels of the underrun concealment
// core. It predicts every result from the accepted frames, checks each
// result beat field by field against the oldest prediction, and reports
// the failure count.
// ----------------------------------------------------------------------------
module suf_frame_checker #(
  parameter int SAMPLE_BITS     = 24,
  parameter int MAX_FADE_FRAMES = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic                             available_i,
  input  wire logic                             mark_break_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_right_i,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  input  wire logic signed [SAMPLE_BITS-1:0]    out_left_o,
  input  wire logic signed [SAMPLE_BITS-1:0]    out_right_o,
  input  wire logic                             episode_start_o,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_o,
  input  wire logic [suf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [suf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                    errors_o,
  output int                                    pending_o,
  output int                                    results_o,
  output int                                    episodes_o,
  output int                                    fade_frames_o
);
  import suf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    episode;
  } frame_out_t;

  localparam longint WEIGHT_ONE  = longint'(1) <<< WEIGHT_FRAC;
  localparam int     MAX_REPORTS = 60;

  logic [RLEN_W-1:0] rlen;
  logic [GAIN_W-1:0] gain;

  logic              starving;
  logic              break_pending;
  logic [RLEN_W-1:0] fade_left;
  sample_t           held_l;
  sample_t           held_r;
  sample_t           fade_from_l;
  sample_t           fade_from_r;

  frame_out_t        expected_frames[$];

  // Multiply by mul / 2^sh with the result truncated toward zero.
  function automatic longint scale_trunc(longint v, longint mul, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * mul) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic int fade_length();
    int l;
    l = rlen;
    if (l < MIN_FADE_FRAMES) l = MIN_FADE_FRAMES;
    if (l > MAX_FADE_FRAMES) l = MAX_FADE_FRAMES;
    return l;
  endfunction

  // Smoothstep 3x^2 - 2x^3 in Q1.16 with x = p / l.
  function automatic longint smooth_weight(int p, int l);
    longint x;
    longint x2;
    x = (longint'(p) <<< WEIGHT_FRAC) / l;
    if (x > WEIGHT_ONE) x = WEIGHT_ONE;
    x2 = (x * x) >>> WEIGHT_FRAC;
    return (x2 * (longint'(POLY_THREE) - 2 * x)) >>> WEIGHT_FRAC;
  endfunction

  task automatic clear_concealment();
    starving      = 1'b0;
    break_pending = 1'b0;
    fade_left     = '0;
    held_l        = '0;
    held_r        = '0;
    fade_from_l   = '0;
    fade_from_r   = '0;
  endtask

  function automatic frame_out_t conceal_frame(logic avail, logic mark,
                                               sample_t in_l, sample_t in_r);
    frame_out_t res;
    int         l;
    int         p;
    longint     w;
    res.episode = 1'b0;
    if (mark) break_pending = 1'b1;
    if (!avail) begin
      res.episode = !starving;
      starving    = 1'b1;
      fade_left   = '0;
      held_l      = scale_trunc(held_l, gain, GAIN_W);
      held_r      = scale_trunc(held_r, gain, GAIN_W);
    end else begin
      l = fade_length();
      if (starving || break_pending) begin
        starving      = 1'b0;
        break_pending = 1'b0;
        fade_left     = l;
        fade_from_l   = held_l;
        fade_from_r   = held_r;
      end
      if (fade_left != 0) begin
        // A fade left over from a longer setting restarts its progress at one.
        p = (fade_left > l) ? 1 : l - fade_left + 1;
        w = smooth_weight(p, l);
        held_l = fade_from_l + scale_trunc(longint'(in_l) - fade_from_l, w, WEIGHT_FRAC);
        held_r = fade_from_r + scale_trunc(longint'(in_r) - fade_from_r, w, WEIGHT_FRAC);
        fade_left--;
        fade_frames_o++;
      end else begin
        held_l = in_l;
        held_r = in_r;
      end
    end
    res.left  = held_l;
    res.right = held_r;
    if (res.episode) episodes_o++;
    return res;
  endfunction

  task automatic check_field(string name, logic signed [SAMPLE_BITS:0] want,
                             logic signed [SAMPLE_BITS:0] got);
    if (got !== want) begin
      if (errors_o < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_out_t want;
    if (!rst_ni) begin
      rlen = RLEN_RESET;
      gain = GAIN_RESET;
      clear_concealment();
      expected_frames.delete();
      errors_o      = 0;
      pending_o     = 0;
      results_o     = 0;
      episodes_o    = 0;
      fade_frames_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RECOVERY_LENGTH: begin
            rlen = cfg_data_i[RLEN_W-1:0];
          end
          CFG_DECAY_GAIN: begin
            gain = cfg_data_i[GAIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // A result beat can never belong to a frame taken at the same edge,
      // so results are matched before the new frame is predicted.
      if (out_valid_o && out_ready_i) begin
        results_o++;
        if (expected_frames.size() == 0) begin
          if (errors_o < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got left %0d right %0d episode %0b",
                     $time, out_left_o, out_right_o, episode_start_o);
          errors_o++;
        end else begin
          want = expected_frames.pop_front();
          check_field("out_left", want.left, out_left_o);
          check_field("out_right", want.right, out_right_o);
          check_field("episode_start", want.episode, episode_start_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (mode_i) begin
          clear_concealment();
        end else begin
          expected_frames.push_back(conceal_frame(available_i, mark_break_i,
                                                  in_left_i, in_right_i));
        end
      end
      pending_o = expected_frames.size();
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_stereo_underrun_fade_recovery_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stereo_underrun_fade_recovery_core: testbench top
// Drives directed and random frame traffic with random gaps and output
// stalls into the concealment core across a series of register settings,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_stereo_underrun_fade_recovery_core;
  import suf_pkg::*;

  localparam int SAMPLE_BITS     = 24;
  localparam int MAX_FADE_FRAMES = 2048;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 80;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   mode_i;
  logic                   available_i;
  logic                   mark_break_i;
  sample_t                in_left_i;
  sample_t                in_right_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  sample_t                out_left_o;
  sample_t                out_right_o;
  logic                   episode_start_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int errors;
  int pending;
  int results;
  int episodes;
  int fade_frames;

  int items_sent  = 0;
  int clears_sent = 0;
  int starve_sent = 0;
  int phases      = 0;
  bit sender_quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  stereo_underrun_fade_recovery_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_FADE_FRAMES(MAX_FADE_FRAMES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .available_i    (available_i),
    .mark_break_i   (mark_break_i),
    .in_left_i      (in_left_i),
    .in_right_i     (in_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .episode_start_o(episode_start_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  suf_frame_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_FADE_FRAMES(MAX_FADE_FRAMES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .available_i    (available_i),
    .mark_break_i   (mark_break_i),
    .in_left_i      (in_left_i),
    .in_right_i     (in_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .episode_start_o(episode_start_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .errors_o       (errors),
    .pending_o      (pending),
    .results_o      (results),
    .episodes_o     (episodes),
    .fade_frames_o  (fade_frames)
  );

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SAMPLE_MAX;
    if (r == 1) return SAMPLE_MIN;
    if (r == 2) return ($urandom_range(0, 1) != 0) ? sample_t'(0) : sample_t'(-1);
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat,
  // with valid still high so that a back-to-back beat needs no toggle.
  task automatic send_item(logic mode, logic avail, logic mark, sample_t l, sample_t r);
    int gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    available_i  <= avail;
    mark_break_i <= mark;
    in_left_i    <= l;
    in_right_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
    if (mode == MODE_CLEAR) clears_sent++;
    else if (!avail) starve_sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every predicted result is out, then let the core
  // settle, since a clear command finishes without a result.
  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic directed_frames();
    send_item(MODE_FRAME, 1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MIN);
    send_item(MODE_FRAME, 1'b1, 1'b0, 0, -1);
    send_item(MODE_FRAME, 1'b1, 1'b0, SAMPLE_MIN, SAMPLE_MAX);
    // Starvation from full-scale held values of both signs.
    send_item(MODE_FRAME, 1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MAX);
    send_item(MODE_FRAME, 1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MIN);
    // A break mark on a starved frame stays pending.
    send_item(MODE_FRAME, 1'b0, 1'b1, -1, 0);
    send_item(MODE_FRAME, 1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MAX);
    repeat (3) send_item(MODE_FRAME, 1'b1, 1'b0, pick_sample(), pick_sample());
    send_item(MODE_FRAME, 1'b1, 1'b1, SAMPLE_MIN, SAMPLE_MIN);
    send_item(MODE_FRAME, 1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MIN);
    // Clear with every other field set: it drops the pending mark too.
    send_item(MODE_CLEAR, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN);
    send_item(MODE_FRAME, 1'b1, 1'b0, 1234, -1234);
    send_item(MODE_FRAME, 1'b0, 1'b0, SAMPLE_MIN, SAMPLE_MAX);
    send_item(MODE_CLEAR, 1'b0, 1'b0, 0, 0);
    send_item(MODE_FRAME, 1'b0, 1'b0, pick_sample(), pick_sample());
    send_item(MODE_FRAME, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN);
    send_item(MODE_FRAME, 1'b1, 1'b0, pick_sample(), pick_sample());
  endtask

  task automatic random_traffic(int n);
    int first;
    int kind;
    int len;
    first = items_sent;
    while (items_sent - first < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 12);
        repeat (len) send_item(MODE_FRAME, 1'b1, $urandom_range(0, 19) == 0,
                               pick_sample(), pick_sample());
      end else if (kind < 75) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(MODE_FRAME, 1'b0, $urandom_range(0, 4) == 0,
                               $urandom, $urandom);
      end else if (kind < 85) begin
        send_item(MODE_FRAME, 1'b1, 1'b1, pick_sample(), pick_sample());
      end else if (kind < 91) begin
        send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 98) begin
        len = $urandom_range(1, 4);
        repeat (len) send_item($urandom_range(0, 7) == 0, $urandom, $urandom,
                               $urandom, $urandom);
      end else begin
        drain($urandom_range(1, 6));
      end
    end
  endtask

  // Each phase ends on a break mark so the next setting starts mid-fade.
  task automatic run_phase(logic [RLEN_W-1:0] rlen, logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] data;
    drain(DRAIN_CYCLES);
    data = $urandom;
    data[RLEN_W-1:0] = rlen;
    write_reg(CFG_RECOVERY_LENGTH, data);
    write_reg(phases[0] ? CFG_UNUSED_HI : CFG_UNUSED_LO, $urandom);
    write_reg(CFG_DECAY_GAIN, gain);
    cfg_valid_i  <= 1'b0;
    phases++;
    sender_quiet = ($urandom_range(0, 3) == 0);
    random_traffic(PHASE_ITEMS);
    send_item(MODE_FRAME, 1'b1, 1'b1, pick_sample(), pick_sample());
  endtask

  initial begin
    int stall;
    int run;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = pick_gap(1'b0);
      run   = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (run) @(negedge clk_i);
    end
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_FRAME;
    available_i  = 1'b0;
    mark_break_i = 1'b0;
    in_left_i    = '0;
    in_right_i   = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_RECOVERY_LENGTH;
    cfg_data_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_frames();
    // Lengths below and above the legal range are clamped by the core.
    run_phase(12'd8, 24'd0);
    run_phase(12'd4095, 24'hFFFFFF);
    run_phase(12'd8, $urandom);
    run_phase(12'd0, 24'h800000);
    run_phase(12'd7, $urandom);
    run_phase(12'd2048, $urandom);
    run_phase(12'd2049, 24'hFFFFFF);
    repeat (6) begin
      run_phase($urandom_range(8, 48), ($urandom_range(0, 3) == 0) ?
                $urandom : $urandom_range(24'hC00000, 24'hFFFFFF));
    end
    drain(DRAIN_CYCLES);

    $display("Run covered %0d items (%0d clears, %0d starved frames) over %0d settings.",
             items_sent, clears_sent, starve_sent, phases + 1);
    $display("Checked %0d results, %0d episode starts and %0d crossfaded frames.",
             results, episodes, fade_frames);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/suf_pkg.sv
hw/rtl/suf_ctrl.sv
hw/rtl/suf_datapath.sv
hw/rtl/stereo_underrun_fade_recovery_core.sv
hw/rtl/suf_checker.sv
sim/suf_frame_checker.sv
sim/tb_stereo_underrun_fade_recovery_core.sv
